[src/nfpc_pkg.sv]
package nfpc_pkg;

  // Op codes as they arrive on the input channel.
  localparam logic [2:0] OP_READ    = 3'd0;
  localparam logic [2:0] OP_PROGRAM = 3'd1;
  localparam logic [2:0] OP_ERASE   = 3'd2;
  localparam logic [2:0] OP_ARM     = 3'd3;
  localparam logic [2:0] OP_DISARM  = 3'd4;

  localparam int OP_W     = 3;
  localparam int ADDR_W   = 16;
  localparam int END_W    = 17;
  localparam int DATA_W   = 8;
  localparam int BUDGET_W = 32;

  // Wide enough to hold the largest supported array size (16 MiB).
  localparam int RANGE_W = 25;

  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  // Queue entries, the item in execution and the output register.
  localparam int MAX_INFLIGHT = QUEUE_DEPTH + 2;

  localparam logic [DATA_W-1:0] ERASED_BYTE = 8'hFF;

  // What the front end decided an item is.
  typedef enum logic [2:0] {
    KIND_READ,
    KIND_PROGRAM,
    KIND_ERASE,
    KIND_ARM,
    KIND_DISARM,
    KIND_NOP,
    KIND_FAIL
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [ADDR_W-1:0]    addr;
    logic [DATA_W-1:0]    data;
    logic [BUDGET_W-1:0]  budget;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } back_state_t;

endpackage

[src/nfpc_in_if.sv]
interface nfpc_in_if;
  logic                             valid;
  logic                             ready;
  logic [nfpc_pkg::OP_W-1:0]        op;
  logic [nfpc_pkg::ADDR_W-1:0]      byte_address;
  logic [nfpc_pkg::END_W-1:0]       access_end;
  logic [nfpc_pkg::DATA_W-1:0]      write_data;
  logic [nfpc_pkg::BUDGET_W-1:0]    cut_bytes;

  modport source (
    output valid, op, byte_address, access_end, write_data, cut_bytes,
    input  ready
  );
  modport sink (
    input  valid, op, byte_address, access_end, write_data, cut_bytes,
    output ready
  );
endinterface

[src/nfpc_out_if.sv]
interface nfpc_out_if;
  logic                        valid;
  logic                        ready;
  logic [nfpc_pkg::DATA_W-1:0] read_data;
  logic                        status;

  modport source (
    output valid, read_data, status,
    input  ready
  );
  modport sink (
    input  valid, read_data, status,
    output ready
  );
endinterface

[src/nfpc_front.sv]
module nfpc_front #(
  parameter int FLASH_BYTES = 65536
) (
  nfpc_in_if.sink         in_ch,
  input  logic            clear_busy,
  input  logic            q_full,
  output logic            push,
  output nfpc_pkg::item_t push_item
);

  localparam logic [nfpc_pkg::RANGE_W-1:0] SIZE = nfpc_pkg::RANGE_W'(FLASH_BYTES);

  logic in_range;

  assign in_ch.ready = !clear_busy && !q_full;
  assign push        = in_ch.valid && in_ch.ready;

  // The access end may sit exactly at the array size; the byte itself must lie inside.
  assign in_range = (nfpc_pkg::RANGE_W'(in_ch.access_end) <= SIZE) &&
                    (nfpc_pkg::RANGE_W'(in_ch.byte_address) < SIZE);

  always_comb begin
    push_item.addr   = in_ch.byte_address;
    push_item.data   = in_ch.write_data;
    push_item.budget = in_ch.cut_bytes;
    case (in_ch.op)
      nfpc_pkg::OP_READ: begin
        push_item.kind = in_range ? nfpc_pkg::KIND_READ : nfpc_pkg::KIND_FAIL;
      end
      nfpc_pkg::OP_PROGRAM: begin
        push_item.kind = in_range ? nfpc_pkg::KIND_PROGRAM : nfpc_pkg::KIND_FAIL;
      end
      nfpc_pkg::OP_ERASE: begin
        push_item.kind = in_range ? nfpc_pkg::KIND_ERASE : nfpc_pkg::KIND_FAIL;
      end
      nfpc_pkg::OP_ARM: begin
        push_item.kind = nfpc_pkg::KIND_ARM;
      end
      nfpc_pkg::OP_DISARM: begin
        push_item.kind = nfpc_pkg::KIND_DISARM;
      end
      default: begin
        push_item.kind = nfpc_pkg::KIND_NOP;
      end
    endcase
  end

endmodule

[src/nfpc_queue.sv]
module nfpc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  nfpc_pkg::item_t   push_item,
  output logic              full,
  output nfpc_pkg::q_head_t head,
  input  logic              pop
);

  nfpc_pkg::item_t                slot_r [nfpc_pkg::QUEUE_DEPTH];
  logic [nfpc_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [nfpc_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [nfpc_pkg::QPTR_W:0]      cnt_r, cnt_nxt;

  assign full       = cnt_r == (nfpc_pkg::QPTR_W + 1)'(nfpc_pkg::QUEUE_DEPTH);
  assign head.valid = cnt_r != '0;
  assign head.item  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == nfpc_pkg::QPTR_W'(nfpc_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == nfpc_pkg::QPTR_W'(nfpc_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[src/nfpc_back.sv]
module nfpc_back #(
  parameter int FLASH_BYTES = 65536
) (
  input  logic              clk,
  input  logic              rst_n,
  input  nfpc_pkg::q_head_t head,
  output logic              pop,
  output logic              clear_busy,
  nfpc_out_if.source        out_ch
);

  // Addresses are 16 bits wide, so a larger array only ever sees its first 64 KiB.
  localparam int MEM_DEPTH = (FLASH_BYTES < 65536) ? FLASH_BYTES : 65536;
  localparam int AW        = $clog2(MEM_DEPTH);

  logic [nfpc_pkg::DATA_W-1:0]   mem [MEM_DEPTH];
  logic [nfpc_pkg::DATA_W-1:0]   mem_rd_r;
  logic                          mem_we;
  logic [AW-1:0]                 mem_wr_idx;
  logic [AW-1:0]                 mem_rd_idx;
  logic [nfpc_pkg::DATA_W-1:0]   mem_wdata;

  nfpc_pkg::back_state_t         state_r, state_nxt;
  logic [AW-1:0]                 clr_idx_r, clr_idx_nxt;
  nfpc_pkg::item_t               cur_r, cur_nxt;
  logic                          armed_r, armed_nxt;
  logic [nfpc_pkg::BUDGET_W-1:0] remaining_r, remaining_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [nfpc_pkg::DATA_W-1:0]   out_data_r, out_data_nxt;
  logic                          out_status_r, out_status_nxt;

  logic                          cut_block;
  logic [nfpc_pkg::DATA_W-1:0]   exec_rd;
  logic                          exec_status;

  assign cut_block  = armed_r && (remaining_r == '0);
  assign clear_busy = state_r == nfpc_pkg::ST_CLEAR;

  // The read is issued as an item leaves the queue and held while it executes.
  assign mem_rd_idx = (state_r == nfpc_pkg::ST_IDLE) ? head.item.addr[AW-1:0]
                                                     : cur_r.addr[AW-1:0];

  assign out_ch.valid     = out_valid_r;
  assign out_ch.read_data = out_data_r;
  assign out_ch.status    = out_status_r;

  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    cur_nxt        = cur_r;
    armed_nxt      = armed_r;
    remaining_nxt  = remaining_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    pop            = 1'b0;
    mem_we         = 1'b0;
    mem_wr_idx     = cur_r.addr[AW-1:0];
    mem_wdata      = nfpc_pkg::ERASED_BYTE;
    exec_rd        = '0;
    exec_status    = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      nfpc_pkg::ST_CLEAR: begin
        mem_we     = 1'b1;
        mem_wr_idx = clr_idx_r;
        if (clr_idx_r == AW'(MEM_DEPTH - 1)) begin
          state_nxt = nfpc_pkg::ST_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + 1'b1;
        end
      end
      nfpc_pkg::ST_IDLE: begin
        if (head.valid) begin
          pop       = 1'b1;
          cur_nxt   = head.item;
          state_nxt = nfpc_pkg::ST_EXEC;
        end
      end
      nfpc_pkg::ST_EXEC: begin
        if (!out_valid_r || out_ch.ready) begin
          case (cur_r.kind)
            nfpc_pkg::KIND_READ: begin
              exec_rd = mem_rd_r;
            end
            nfpc_pkg::KIND_PROGRAM: begin
              // After the cut the program is dropped but still reports success.
              if (!cut_block) begin
                mem_we    = 1'b1;
                mem_wdata = mem_rd_r & cur_r.data;
                if (armed_r) begin
                  remaining_nxt = remaining_r - 1'b1;
                end
              end
            end
            nfpc_pkg::KIND_ERASE: begin
              if (cut_block) begin
                exec_status = 1'b1;
              end else begin
                mem_we = 1'b1;
              end
            end
            nfpc_pkg::KIND_ARM: begin
              remaining_nxt = cur_r.budget;
              armed_nxt     = 1'b1;
            end
            nfpc_pkg::KIND_DISARM: begin
              armed_nxt = 1'b0;
            end
            nfpc_pkg::KIND_FAIL: begin
              exec_status = 1'b1;
            end
            default: begin
            end
          endcase
          out_valid_nxt  = 1'b1;
          out_data_nxt   = exec_rd;
          out_status_nxt = exec_status;
          state_nxt      = nfpc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = nfpc_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nfpc_pkg::ST_CLEAR;
      clr_idx_r   <= '0;
      armed_r     <= 1'b0;
      remaining_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      armed_r     <= armed_nxt;
      remaining_r <= remaining_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wr_idx] <= mem_wdata;
    end
    mem_rd_r <= mem[mem_rd_idx];
  end

endmodule

[src/nor_flash_model_with_power_cut_unit.sv]
// Channel   Dir  Handshake           Payload
// in_ch     in   valid/ready         op, byte_address, access_end, write_data, cut_bytes
// out_ch    out  valid/ready         read_data, status
//
// Each word goes through ST_IDLE, which issues the registered read of the flash array
// as the word leaves the queue, then ST_EXEC, which does the read-modify-write and
// registers the result; no new word is taken before that. After reset the array is
// swept to 0xFF, one byte a cycle, over min(FLASH_BYTES, 65536) bytes (65536 by
// default) while in_ch.ready stays low. A result stalled in the output register holds
// the back end, and the two-entry queue keeps accepting words until it is full.
module nor_flash_model_with_power_cut_unit #(
  parameter int FLASH_BYTES = 65536
) (
  input  logic       clk,
  input  logic       rst_n,
  nfpc_in_if.sink    in_ch,
  nfpc_out_if.source out_ch
);

  // Front end: handshake, op decode and range check. An out-of-range read,
  // program or erase is turned into a plain failure here, so the back end
  // never writes the array or returns its data for it.
  logic              push;
  nfpc_pkg::item_t   push_item;
  logic              q_full;
  logic              clear_busy;

  // Queue to back end.
  nfpc_pkg::q_head_t q_head;
  logic              pop;

  nfpc_front #(
    .FLASH_BYTES (FLASH_BYTES)
  ) u_front (
    .in_ch      (in_ch),
    .clear_busy (clear_busy),
    .q_full     (q_full),
    .push       (push),
    .push_item  (push_item)
  );

  // The queue lets the front keep accepting words while the back end is
  // waiting on a stalled output.
  nfpc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .head      (q_head),
    .pop       (pop)
  );

  // Back end: owns the flash array, the power-cut budget and the output
  // register. Programs AND into the stored byte, erases write 0xFF, and once
  // an armed budget hits zero programs are dropped and erases fail.
  nfpc_back #(
    .FLASH_BYTES (FLASH_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .pop        (pop),
    .clear_busy (clear_busy),
    .out_ch     (out_ch)
  );

endmodule

[src/nfpc_checker.sv]
module nfpc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [nfpc_pkg::DATA_W-1:0] out_read_data,
  input logic                        out_status
);

  localparam int CNT_W = $clog2(nfpc_pkg::MAX_INFLIGHT + 1);

  logic             in_acc;
  logic             out_acc;
  logic [CNT_W-1:0] inflight_r;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Words accepted whose result has not yet been taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else if (in_acc && !out_acc) begin
      inflight_r <= inflight_r + 1'b1;
    end else if (out_acc && !in_acc) begin
      inflight_r <= inflight_r - 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data) && $stable(out_status))
    else $error("result changed or dropped while stalled");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> inflight_r != '0)
    else $error("result offered with no word outstanding");

  a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= CNT_W'(nfpc_pkg::MAX_INFLIGHT))
    else $error("more words in flight than the queue and registers can hold");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_read_data == '0)
    else $error("failed access returned nonzero data");

  a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !in_ready)
    else $error("input accepted before the array sweep");

endmodule

bind nor_flash_model_with_power_cut_unit nfpc_checker u_nfpc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_read_data (out_ch.read_data),
  .out_status    (out_ch.status)
);
